@@ sv/mmm_pkg.sv @@
// ----------------------------------------------------------------------------
// Matrix multiply package
// Shared codes and types for the bit-serial matrix multiply unit.
// ----------------------------------------------------------------------------
`default_nettype none
package mmm_pkg;

	// Input item kinds.
	localparam logic [1:0] KIND_WRITE_A = 2'd0;
	localparam logic [1:0] KIND_WRITE_B = 2'd1;
	localparam logic [1:0] KIND_COMPUTE = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_ROWS  = 2'd0;
	localparam logic [1:0] REG_INNER = 2'd1;
	localparam logic [1:0] REG_COLS  = 2'd2;

	localparam int SUM_BITS = 35;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_START,
		ST_MUL,
		ST_ACC,
		ST_EMIT
	} state_t;

	// Control from the sequencer to the bit-serial multiplier.
	typedef struct packed {
		logic start;
	} mul_ctrl_t;

endpackage
`default_nettype wire

@@ sv/mmm_serial_mul.sv @@
// ----------------------------------------------------------------------------
// Bit-serial signed multiplier
// Shift-add multiplier that retires one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module mmm_serial_mul #(
	parameter int W = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire mmm_pkg::mul_ctrl_t     ctrl,
	input  wire logic signed [W-1:0]    a,
	input  wire logic signed [W-1:0]    b,
	output logic                        done,
	output logic signed [2*W-1:0]       prod
);
	localparam int CW = $clog2(W + 1);

	logic signed [2*W-1:0] mcand_q;
	logic        [W-1:0]   mplier_q;
	logic signed [2*W-1:0] acc_q;
	logic        [CW-1:0]  cnt_q;
	logic                  busy_q;
	logic                  done_q;

	// One multiplier bit per cycle; the top bit carries negative weight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			mcand_q  <= (2*W)'(a);
			mplier_q <= b;
			acc_q    <= '0;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				if (cnt_q == CW'(W - 1)) acc_q <= acc_q - mcand_q;
				else                     acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

	property p_done_after_busy;
		@(posedge clk) disable iff (!arst_n) done_q |-> $past(busy_q);
	endproperty
	a_done_after_busy: assert property (p_done_after_busy) else $error("done without busy");

	property p_start_busy;
		@(posedge clk) disable iff (!arst_n) ctrl.start |=> busy_q;
	endproperty
	a_start_busy: assert property (p_start_busy) else $error("start did not begin work");

	property p_no_restart;
		@(posedge clk) disable iff (!arst_n) busy_q |-> !ctrl.start;
	endproperty
	a_no_restart: assert property (p_no_restart) else $error("start while busy");

endmodule
`default_nettype wire

@@ sv/matrix_multiply_mac_unit.sv @@
// ----------------------------------------------------------------------------
// Matrix multiply MAC unit
// Computes C = A x B from stored elements, one bit-serial product at a time.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   kind, row, col, value
// out      output     out_valid / out_stall out_row, out_col, sum, last
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// For each product of a compute item the sequencer steps through read, start,
// multiply and accumulate, and the bit-serial multiplier retires one bit per
// cycle; each result element then takes one emit step.
// Reset clears control state and sets each dimension to its maximum.
// A stalled result holds the sequencer at its next emit step until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module matrix_multiply_mac_unit #(
	parameter int MAX_DIM   = 8,
	parameter int ELEM_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         kind,
	input  wire logic [2:0]         row,
	input  wire logic [2:0]         col,
	input  wire logic signed [15:0] value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              out_row,
	output logic [2:0]              out_col,
	output logic signed [34:0]      sum,
	output logic                    last,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [3:0]         cfg_data
);
	localparam int DB    = $clog2(MAX_DIM);
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int SB    = mmm_pkg::SUM_BITS;

	logic [ELEM_BITS-1:0] a_mem [DEPTH];
	logic [ELEM_BITS-1:0] b_mem [DEPTH];
	logic [ELEM_BITS-1:0] a_rd_q, b_rd_q;

	logic [3:0] rows_q, inner_q, cols_q;
	logic [3:0] nr, nk, nc;
	logic [DB-1:0] i_q, j_q, k_q;
	logic signed [SB-1:0] acc_q;
	mmm_pkg::state_t state_q, state_d;
	mmm_pkg::mul_ctrl_t mctl;
	logic mul_done;
	logic signed [2*ELEM_BITS-1:0] prod;
	logic in_acc, wr_ok, emit_go;
	logic last_k, last_j, last_i;
	logic [2:0] orow_q, ocol_q;
	logic signed [SB-1:0] osum_q;
	logic olast_q, ovalid_q;

	function automatic logic [3:0] clamp(input logic [3:0] v);
		if (v == 4'd0) return 4'd1;
		if (v > 4'(MAX_DIM)) return 4'(MAX_DIM);
		return v;
	endfunction

	assign nr = clamp(rows_q);
	assign nk = clamp(inner_q);
	assign nc = clamp(cols_q);
	assign last_k = (4'(k_q) == 4'(nk - 4'd1));
	assign last_j = (4'(j_q) == 4'(nc - 4'd1));
	assign last_i = (4'(i_q) == 4'(nr - 4'd1));

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != mmm_pkg::ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign wr_ok     = ({1'b0, row} < 4'(MAX_DIM)) && ({1'b0, col} < 4'(MAX_DIM));
	assign emit_go   = (state_q == mmm_pkg::ST_EMIT) && (!ovalid_q || !out_stall);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= 4'(MAX_DIM);
			inner_q <= 4'(MAX_DIM);
			cols_q  <= 4'(MAX_DIM);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mmm_pkg::REG_ROWS:  rows_q  <= cfg_data;
				mmm_pkg::REG_INNER: inner_q <= cfg_data;
				mmm_pkg::REG_COLS:  cols_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Element stores: written by load beats, read with a registered port.
	always_ff @(posedge clk) begin
		if (in_acc && wr_ok && kind == mmm_pkg::KIND_WRITE_A)
			a_mem[AW'(row) * AW'(MAX_DIM) + AW'(col)] <= ELEM_BITS'(value);
		if (in_acc && wr_ok && kind == mmm_pkg::KIND_WRITE_B)
			b_mem[AW'(row) * AW'(MAX_DIM) + AW'(col)] <= ELEM_BITS'(value);
		a_rd_q <= a_mem[AW'(i_q) * AW'(MAX_DIM) + AW'(k_q)];
		b_rd_q <= b_mem[AW'(k_q) * AW'(MAX_DIM) + AW'(j_q)];
	end

	mmm_serial_mul #(.W(ELEM_BITS)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mctl),
		.a      (a_rd_q),
		.b      (b_rd_q),
		.done   (mul_done),
		.prod   (prod)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mmm_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// Next state and multiplier start. The read step lets the store outputs
	// catch up with the counters before the multiplier takes its operands.
	always_comb begin
		state_d    = state_q;
		mctl.start = 1'b0;
		unique case (state_q)
			mmm_pkg::ST_IDLE: begin
				if (in_acc && kind == mmm_pkg::KIND_COMPUTE) state_d = mmm_pkg::ST_READ;
			end
			mmm_pkg::ST_READ: begin
				state_d = mmm_pkg::ST_START;
			end
			mmm_pkg::ST_START: begin
				mctl.start = 1'b1;
				state_d    = mmm_pkg::ST_MUL;
			end
			mmm_pkg::ST_MUL: begin
				if (mul_done) state_d = mmm_pkg::ST_ACC;
			end
			mmm_pkg::ST_ACC: begin
				state_d = last_k ? mmm_pkg::ST_EMIT : mmm_pkg::ST_READ;
			end
			mmm_pkg::ST_EMIT: begin
				if (!ovalid_q || !out_stall)
					state_d = (last_i && last_j) ? mmm_pkg::ST_IDLE : mmm_pkg::ST_READ;
			end
			default: state_d = mmm_pkg::ST_IDLE;
		endcase
	end

	// Loop counters and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0; j_q <= '0; k_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			ovalid_q <= emit_go || (ovalid_q && out_stall);
			if (state_q == mmm_pkg::ST_IDLE) begin
				i_q <= '0; j_q <= '0; k_q <= '0;
			end else if (state_q == mmm_pkg::ST_ACC && !last_k) begin
				k_q <= k_q + 1'b1;
			end else if (emit_go) begin
				k_q <= '0;
				if (last_j) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mmm_pkg::ST_IDLE) acc_q <= '0;
		else if (state_q == mmm_pkg::ST_ACC) acc_q <= acc_q + SB'(prod);
		else if (emit_go) acc_q <= '0;
		if (emit_go) begin
			orow_q  <= 3'(i_q);
			ocol_q  <= 3'(j_q);
			osum_q  <= acc_q;
			olast_q <= last_i && last_j;
		end
	end

	assign out_valid = ovalid_q;
	assign out_row   = orow_q;
	assign out_col   = ocol_q;
	assign sum       = osum_q;
	assign last      = olast_q;

	property p_hold_out;
		@(posedge clk) disable iff (!arst_n)
			out_valid && out_stall |=> out_valid && $stable(sum) && $stable(last);
	endproperty
	a_hold_out: assert property (p_hold_out) else $error("stalled result changed");

	property p_busy_stall;
		@(posedge clk) disable iff (!arst_n)
			state_q == mmm_pkg::ST_MUL |-> in_stall;
	endproperty
	a_busy_stall: assert property (p_busy_stall) else $error("input open while computing");

	property p_emit_from_acc;
		@(posedge clk) disable iff (!arst_n)
			$rose(out_valid) |-> $past(state_q == mmm_pkg::ST_EMIT);
	endproperty
	a_emit_from_acc: assert property (p_emit_from_acc) else $error("result from wrong state");

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Matrix multiply MAC unit testbench
// Loads A and B elements, runs products under several dimension settings and
// checks every result element, in order, against a predicted product.
// ----------------------------------------------------------------------------

// A predicted result element.
typedef struct {
	bit [2:0]  r;
	bit [2:0]  c;
	bit [34:0] s;
	bit        l;
} product_elem_t;

// Keeps its own copy of both stores and the dimensions, and the queue of
// result elements that the unit still owes.
class mac_scoreboard;
	logic signed [15:0] a_mem [64];
	logic signed [15:0] b_mem [64];
	bit [3:0]           dim [3];
	product_elem_t      owed [$];
	int                 mismatches;

	function new();
		dim = '{4'd8, 4'd8, 4'd8};
		mismatches = 0;
	endfunction

	// A register value of zero acts as one, values above eight act as eight.
	function int eff_dim(int idx);
		if (dim[idx] == 0) return 1;
		if (dim[idx] > 8) return 8;
		return dim[idx];
	endfunction

	function void set_reg(bit [1:0] idx, bit [3:0] data);
		if (idx <= mmm_pkg::REG_COLS) dim[idx] = data;
	endfunction

	function int pending();
		return owed.size();
	endfunction

	function void note_item(bit [1:0] kind, bit [2:0] row, bit [2:0] col,
			logic signed [15:0] value);
		int nr, nk, nc;
		longint acc;
		product_elem_t e;
		case (kind)
			mmm_pkg::KIND_WRITE_A: a_mem[{row, col}] = value;
			mmm_pkg::KIND_WRITE_B: b_mem[{row, col}] = value;
			mmm_pkg::KIND_COMPUTE: begin
				nr = eff_dim(mmm_pkg::REG_ROWS);
				nk = eff_dim(mmm_pkg::REG_INNER);
				nc = eff_dim(mmm_pkg::REG_COLS);
				for (int i = 0; i < nr; i++) begin
					for (int j = 0; j < nc; j++) begin
						acc = 0;
						for (int k = 0; k < nk; k++)
							acc += longint'(a_mem[i * 8 + k]) * longint'(b_mem[k * 8 + j]);
						e.r = 3'(i);
						e.c = 3'(j);
						e.s = acc[34:0];
						e.l = (i == nr - 1) && (j == nc - 1);
						owed.push_back(e);
					end
				end
			end
			default: ;
		endcase
	endfunction

	function void check_result(bit [2:0] r, bit [2:0] c, bit [34:0] s, bit l);
		product_elem_t e;
		if (owed.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Unexpected result beat: row %0d col %0d sum %0d last %0d",
					r, c, $signed(s), l);
			return;
		end
		e = owed.pop_front();
		if (e.r != r || e.c != c || e.s != s || e.l != l) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Result mismatch: expected row %0d col %0d sum %0d last %0d, got row %0d col %0d sum %0d last %0d",
					e.r, e.c, $signed(e.s), e.l, r, c, $signed(s), l);
		end
	endfunction
endclass

module tb_top;

	localparam logic [1:0] KIND_NONE  = 2'd3;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 20000;
	localparam int ITEM_TARGET = 280;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         kind = '0;
	logic [2:0]         row = '0;
	logic [2:0]         col = '0;
	logic signed [15:0] value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [2:0]         out_row;
	logic [2:0]         out_col;
	logic signed [34:0] sum;
	logic               last;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [3:0]         cfg_data = '0;

	mac_scoreboard sb = new();
	bit  a_written [64];
	bit  b_written [64];
	bit  calm = 1'b0;
	bit  long_hold_done = 1'b0;
	int  items_sent = 0;
	int  results_seen = 0;
	int  hold_left = 0;
	int  quiet_cycles = 0;

	matrix_multiply_mac_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .row(row), .col(col), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_row(out_row), .out_col(out_col), .sum(sum), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offer one input beat, with random idle cycles ahead of it. Valid stays
	// high afterwards so that back-to-back beats need no second assignment.
	task automatic send_item(logic [1:0] k, logic [2:0] r, logic [2:0] c,
			logic signed [15:0] v);
		while (!calm && $urandom_range(0, 99) < 38) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		row <= r;
		col <= c;
		value <= v;
		do @(posedge clk); while (in_stall);
		sb.note_item(k, r, c, v);
		items_sent++;
		if (k == mmm_pkg::KIND_WRITE_A) a_written[{r, c}] = 1'b1;
		if (k == mmm_pkg::KIND_WRITE_B) b_written[{r, c}] = 1'b1;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [3:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait until every owed result has come, then let the unit settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			default: return 16'($urandom());
		endcase
	endfunction

	// Write every element a product would read that has not been written yet,
	// then issue the product.
	task automatic fill_and_compute();
		int nr, nk, nc;
		nr = sb.eff_dim(mmm_pkg::REG_ROWS);
		nk = sb.eff_dim(mmm_pkg::REG_INNER);
		nc = sb.eff_dim(mmm_pkg::REG_COLS);
		for (int i = 0; i < nr; i++)
			for (int k = 0; k < nk; k++)
				if (!a_written[i * 8 + k])
					send_item(mmm_pkg::KIND_WRITE_A, 3'(i), 3'(k), pick_value());
		for (int k = 0; k < nk; k++)
			for (int j = 0; j < nc; j++)
				if (!b_written[k * 8 + j])
					send_item(mmm_pkg::KIND_WRITE_B, 3'(k), 3'(j), pick_value());
		send_item(mmm_pkg::KIND_COMPUTE, 3'($urandom()), 3'($urandom()), 16'($urandom()));
	endtask

	// Result side: check each accepted beat and stall at random, with one
	// long hold-off while the sender keeps offering.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(out_row, out_col, sum, last);
			results_seen++;
			if (results_seen >= 40 && !long_hold_done && in_valid && in_stall) begin
				hold_left = 400;
				long_hold_done = 1'b1;
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(0, 99) < 38);
		end
	end

	// Watchdog on cycles with no accepted beat on any channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int phase;
		int batch;
		int pick;
		int nr, nk, nc;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme values in a 2x2x2 product, unused store corner,
		// an unused kind, then out-of-range register values.
		write_reg(mmm_pkg::REG_ROWS, 4'd2);
		write_reg(mmm_pkg::REG_INNER, 4'd2);
		write_reg(mmm_pkg::REG_COLS, 4'd2);
		send_item(mmm_pkg::KIND_WRITE_A, 0, 0, 16'sh8000);
		send_item(mmm_pkg::KIND_WRITE_A, 0, 1, 16'sh7fff);
		send_item(mmm_pkg::KIND_WRITE_A, 1, 0, 16'sh8000);
		send_item(mmm_pkg::KIND_WRITE_A, 1, 1, -16'sd1);
		send_item(mmm_pkg::KIND_WRITE_B, 0, 0, 16'sh8000);
		send_item(mmm_pkg::KIND_WRITE_B, 0, 1, 16'sh8000);
		send_item(mmm_pkg::KIND_WRITE_B, 1, 0, 16'sh7fff);
		send_item(mmm_pkg::KIND_WRITE_B, 1, 1, 16'sd1);
		send_item(mmm_pkg::KIND_WRITE_A, 7, 7, 16'sh7fff);
		send_item(mmm_pkg::KIND_WRITE_B, 7, 7, 16'sh8000);
		send_item(KIND_NONE, 7, 7, 16'shffff);
		send_item(mmm_pkg::KIND_COMPUTE, 7, 7, 16'shffff);
		drain();
		write_reg(mmm_pkg::REG_ROWS, 4'd0);
		write_reg(mmm_pkg::REG_INNER, 4'd15);
		write_reg(mmm_pkg::REG_COLS, 4'd1);
		write_reg(REG_UNUSED, 4'd5);
		fill_and_compute();
		drain();

		// Random phases, each under its own dimensions.
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			calm = (phase == 3);
			if (phase == 2 || phase == 9) begin
				nr = 8; nk = 8; nc = 8;
			end else begin
				nr = $urandom_range(1, 3);
				nk = $urandom_range(1, 3);
				nc = $urandom_range(1, 3);
				if ($urandom_range(0, 5) == 0) nk = 0;
				if ($urandom_range(0, 5) == 0) nc = 15;
			end
			write_reg(mmm_pkg::REG_ROWS, 4'(nr));
			write_reg(mmm_pkg::REG_INNER, 4'(nk));
			write_reg(mmm_pkg::REG_COLS, 4'(nc));
			if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 4'($urandom()));
			nr = sb.eff_dim(mmm_pkg::REG_ROWS);
			nk = sb.eff_dim(mmm_pkg::REG_INNER);
			nc = sb.eff_dim(mmm_pkg::REG_COLS);
			batch = $urandom_range(15, 30);
			for (int n = 0; n < batch; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 6)
					send_item(KIND_NONE, 3'($urandom()), 3'($urandom()), 16'($urandom()));
				else if (pick < 45)
					send_item(mmm_pkg::KIND_WRITE_A,
						3'(($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, nr - 1)),
						3'(($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, nk - 1)),
						pick_value());
				else if (pick < 84)
					send_item(mmm_pkg::KIND_WRITE_B,
						3'(($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, nk - 1)),
						3'(($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, nc - 1)),
						pick_value());
				else
					fill_and_compute();
			end
			fill_and_compute();
			drain();
			phase++;
		end

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ sim.f @@
sv/mmm_pkg.sv
sv/mmm_serial_mul.sv
sv/matrix_multiply_mac_unit.sv
dv/tb_top.sv
